[sv/srrc_pkg.sv]
package srrc_pkg;

  // Field widths of the channels
  localparam int CP_W     = 21;
  localparam int DUR_W    = 25;
  localparam int CFG_W    = 16;
  localparam int VIS_W    = 12;
  localparam int RATE_W   = 17;
  localparam int STATUS_W = 2;

  // Defaults
  localparam int COUNT_WIDTH_DEF = 12;
  localparam logic [CFG_W-1:0] MIN_DUR_RESET = 16'd100;

  // Rate status codes
  localparam logic [STATUS_W-1:0] ST_COMPUTED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_POSITIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT    = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic special;
    logic div_done;
  } dp_status_t;

endpackage

[sv/srrc_if.sv]
interface srrc_item_if;
  logic                       valid;
  logic                       ready;
  logic [srrc_pkg::CP_W-1:0]  code_point;
  logic                       char_valid;
  logic                       is_last;
  logic signed [srrc_pkg::DUR_W-1:0] span_ms;

  modport source (output valid, code_point, char_valid, is_last, span_ms, input ready);
  modport sink   (input valid, code_point, char_valid, is_last, span_ms, output ready);
endinterface

interface srrc_result_if;
  logic                              valid;
  logic                              ready;
  logic [srrc_pkg::VIS_W-1:0]        visible_chars;
  logic signed [srrc_pkg::RATE_W-1:0] chars_per_second;
  logic [srrc_pkg::STATUS_W-1:0]     rate_status;

  modport source (output valid, visible_chars, chars_per_second, rate_status, input ready);
  modport sink   (input valid, visible_chars, chars_per_second, rate_status, output ready);
endinterface

interface srrc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [srrc_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/srrc_ctrl.sv]
module srrc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_last,
  output logic                   item_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  srrc_pkg::dp_status_t   sts,
  output srrc_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign item_ready = (state == S_IDLE);

  // Sequence one entry: take items, divide, hand over the result
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = item_valid && item_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && item_last) begin
          cmd.start  = 1'b1;
          state_next = sts.special ? S_HOLD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Track the output register
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[sv/srrc_datapath.sv]
module srrc_datapath #(
  parameter int COUNT_WIDTH = srrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  srrc_pkg::ctrl_cmd_t                  cmd,
  output srrc_pkg::dp_status_t                 sts,
  input  logic [srrc_pkg::CP_W-1:0]            code_point,
  input  logic                                 char_valid,
  input  logic                                 is_last,
  input  logic signed [srrc_pkg::DUR_W-1:0]    span_ms,
  input  logic                                 cfg_we,
  input  logic [srrc_pkg::CFG_W-1:0]           cfg_data,
  output logic [srrc_pkg::VIS_W-1:0]           visible_chars,
  output logic signed [srrc_pkg::RATE_W-1:0]   chars_per_second,
  output logic [srrc_pkg::STATUS_W-1:0]        rate_status
);

  localparam int CPW    = srrc_pkg::CP_W;
  localparam int NUM_W  = COUNT_WIDTH + 10;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int DMAG_W = srrc_pkg::DUR_W - 1;

  localparam logic [CPW-1:0] CH_TAB    = 21'h09;
  localparam logic [CPW-1:0] CH_LF     = 21'h0A;
  localparam logic [CPW-1:0] CH_CR_MAX = 21'h0D;
  localparam logic [CPW-1:0] CH_CR     = 21'h0D;
  localparam logic [CPW-1:0] CH_SPACE  = 21'h20;
  localparam logic [CPW-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CPW-1:0] CH_LT     = 21'h3C;
  localparam logic [CPW-1:0] CH_GT     = 21'h3E;
  localparam logic [CPW-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CPW-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CPW-1:0] CH_UPPER_N = 21'h4E;
  localparam logic [CPW-1:0] CH_LOWER_N = 21'h6E;

  localparam logic [COUNT_WIDTH-1:0] CAP   = '1;
  localparam logic [NUM_W-1:0]       MUL_K = NUM_W'(1000);
  localparam logic [srrc_pkg::RATE_W-1:0] RATE_SAT = 17'd65535;
  localparam logic [srrc_pkg::RATE_W-1:0] RATE_NEG = '1;

  typedef struct packed {
    logic angle;
    logic brace;
    logic space_pend;
    logic seen;
  } tag_flags_t;

  typedef struct packed {
    tag_flags_t f;
    logic [1:0] inc;
  } tag_res_t;

  // One character through tag stripping and space collapsing
  function automatic tag_res_t tag_step(tag_flags_t f, logic [CPW-1:0] c);
    tag_res_t        r;
    logic [CPW-1:0]  cc;
    logic            ws;
    r.f   = f;
    r.inc = 2'd0;
    cc    = (c == CH_LF) ? CH_SPACE : c;
    ws    = (cc == CH_SPACE) || ((cc >= CH_TAB) && (cc <= CH_CR_MAX));
    if (!f.angle && !f.brace) begin
      if (c == CH_LT) begin
        r.f.angle = 1'b1;
      end else if (c == CH_LBRACE) begin
        r.f.brace = 1'b1;
      end else if (ws) begin
        if (f.seen) begin
          r.f.space_pend = 1'b1;
        end
      end else begin
        r.inc          = (f.seen && f.space_pend) ? 2'd2 : 2'd1;
        r.f.seen       = 1'b1;
        r.f.space_pend = 1'b0;
      end
    end else if (f.angle && (c == CH_GT)) begin
      r.f.angle = 1'b0;
    end else if (f.brace && (c == CH_RBRACE)) begin
      r.f.brace = 1'b0;
    end
    return r;
  endfunction

  // Entry state
  tag_flags_t             flags;
  logic                   held_bs;
  logic                   held_cr;
  logic [COUNT_WIDTH-1:0] count;
  logic [srrc_pkg::CFG_W-1:0] min_dur;

  // Break handling and tag chain
  logic                   a_vld, b_vld;
  logic [CPW-1:0]         a_ch, b_ch;
  logic                   held_bs_next, held_cr_next;
  logic                   consumed;
  tag_res_t               res_a, res_b;
  tag_flags_t             flags_mid, flags_next;
  logic [COUNT_WIDTH:0]   count_sum;
  logic [COUNT_WIDTH-1:0] count_sat;

  // Divider and result
  logic [NUM_W-1:0]       numq;
  logic [DMAG_W-1:0]      rem;
  logic [DMAG_W-1:0]      dur_q;
  logic [STEP_W-1:0]      step_cnt;
  logic [srrc_pkg::STATUS_W-1:0] code;
  logic [srrc_pkg::STATUS_W-1:0] code_in;
  logic [COUNT_WIDTH-1:0] vis_hold;
  logic [DMAG_W:0]        trial;
  logic [DMAG_W:0]        diff;
  logic                   ge;
  logic                   not_pos;
  logic                   too_short;
  logic [COUNT_WIDTH+srrc_pkg::VIS_W-1:0] vis_ext;

  // Turn line-break forms into newlines and pick up to two characters for the tag chain
  always_comb begin
    a_vld        = 1'b0;
    b_vld        = 1'b0;
    a_ch         = CH_LF;
    b_ch         = code_point;
    held_bs_next = held_bs;
    held_cr_next = held_cr;
    consumed     = 1'b0;
    if (char_valid) begin
      if (held_cr) begin
        held_cr_next = 1'b0;
        a_vld        = 1'b1;
        a_ch         = CH_LF;
        consumed     = (code_point == CH_LF);
      end
      if (held_bs && !consumed) begin
        held_bs_next = 1'b0;
        a_vld        = 1'b1;
        if ((code_point == CH_UPPER_N) || (code_point == CH_LOWER_N)) begin
          a_ch     = CH_LF;
          consumed = 1'b1;
        end else begin
          a_ch = CH_BSLASH;
        end
      end
      if (!consumed) begin
        if (code_point == CH_CR) begin
          held_cr_next = 1'b1;
        end else if (code_point == CH_BSLASH) begin
          held_bs_next = 1'b1;
        end else begin
          b_vld = 1'b1;
          b_ch  = code_point;
        end
      end
    end
    // Flush a held mark at the end of the entry
    if (is_last) begin
      if (held_cr_next) begin
        b_vld = 1'b1;
        b_ch  = CH_LF;
      end else if (held_bs_next) begin
        b_vld = 1'b1;
        b_ch  = CH_BSLASH;
      end
    end
  end

  always_comb begin
    res_a      = tag_step(flags, a_ch);
    flags_mid  = a_vld ? res_a.f : flags;
    res_b      = tag_step(flags_mid, b_ch);
    flags_next = b_vld ? res_b.f : flags_mid;
    count_sum  = {1'b0, count}
               + (COUNT_WIDTH+1)'(a_vld ? res_a.inc : 2'd0)
               + (COUNT_WIDTH+1)'(b_vld ? res_b.inc : 2'd0);
    count_sat  = (count_sum > {1'b0, CAP}) ? CAP : count_sum[COUNT_WIDTH-1:0];
  end

  // Classify the duration
  always_comb begin
    not_pos   = span_ms[srrc_pkg::DUR_W-1] || (span_ms == '0);
    too_short = (span_ms[DMAG_W-1:0] <= DMAG_W'(min_dur));
    if (not_pos) begin
      code_in = srrc_pkg::ST_NOT_POSITIVE;
    end else if (too_short) begin
      code_in = srrc_pkg::ST_TOO_SHORT;
    end else begin
      code_in = srrc_pkg::ST_COMPUTED;
    end
  end

  assign sts.special  = (code_in != srrc_pkg::ST_COMPUTED);
  assign sts.div_done = (step_cnt == '0);

  // Restoring division step
  always_comb begin
    trial = {rem, numq[NUM_W-1]};
    diff  = trial - {1'b0, dur_q};
    ge    = (trial >= {1'b0, dur_q});
  end

  assign vis_ext = {{srrc_pkg::VIS_W{1'b0}}, vis_hold};

  // Hold entry state and the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      held_bs <= 1'b0;
      held_cr <= 1'b0;
      count   <= '0;
      min_dur <= srrc_pkg::MIN_DUR_RESET;
    end else begin
      if (cfg_we) begin
        min_dur <= cfg_data;
      end
      if (cmd.accept) begin
        if (is_last) begin
          flags   <= '0;
          held_bs <= 1'b0;
          held_cr <= 1'b0;
          count   <= '0;
        end else begin
          flags   <= flags_next;
          held_bs <= held_bs_next;
          held_cr <= held_cr_next;
          count   <= count_sat;
        end
      end
    end
  end

  // Load, iterate and deliver the rate
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      numq     <= NUM_W'(count_sat) * MUL_K;
      rem      <= '0;
      dur_q    <= span_ms[DMAG_W-1:0];
      step_cnt <= STEP_W'(NUM_W - 1);
      code     <= code_in;
      vis_hold <= count_sat;
    end else if (cmd.step) begin
      numq     <= {numq[NUM_W-2:0], ge};
      rem      <= ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
      step_cnt <= step_cnt - 1'b1;
    end
    if (cmd.load_out) begin
      visible_chars <= vis_ext[srrc_pkg::VIS_W-1:0];
      rate_status   <= code;
      unique case (code)
        srrc_pkg::ST_COMPUTED: begin
          chars_per_second <= (numq[NUM_W-1:16] != '0) ? RATE_SAT : {1'b0, numq[15:0]};
        end
        srrc_pkg::ST_TOO_SHORT: begin
          chars_per_second <= RATE_NEG;
        end
        default: begin
          chars_per_second <= '0;
        end
      endcase
    end
  end

endmodule

[sv/subtitle_reading_rate_counter.sv]
// Counts the characters a reader sees in one subtitle entry, fed one code point per item,
// and gives the count with characters per second on the item marked last. Items that are not
// last are taken one per cycle. A last item starts a restoring divider that settles one
// quotient bit a cycle, then the output register is loaded; when the duration is not
// positive or too short the divider is skipped and the output register is loaded directly.
// No item is taken while the divider runs or while a finished result waits for the output
// register to free. The minimum duration register may be written at any time the block is
// idle and resets to 100 ms.
module subtitle_reading_rate_counter #(
  parameter int COUNT_WIDTH = srrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  srrc_item_if.sink       item,
  srrc_result_if.source   result,
  srrc_cfg_if.sink        cfg
);

  srrc_pkg::ctrl_cmd_t  cmd;
  srrc_pkg::dp_status_t sts;

  // Always take configuration writes
  assign cfg.ready = 1'b1;

  srrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_last  (item.is_last),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  srrc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .code_point       (item.code_point),
    .char_valid       (item.char_valid),
    .is_last          (item.is_last),
    .span_ms          (item.span_ms),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_data         (cfg.data),
    .visible_chars    (result.visible_chars),
    .chars_per_second (result.chars_per_second),
    .rate_status      (result.rate_status)
  );

`ifndef NO_ASSERTIONS
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.is_last |=> !item.ready)
    else $error("input still open after a last item");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("output register overwritten while full");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !item.ready && !cmd.accept)
    else $error("item taken while dividing");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE         = 40;
  localparam int HOLD_OFF       = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 180;
  localparam longint RATE_MAX   = 65535;

  // Code points the text filter reacts to, and the first lowercase letter
  localparam bit [srrc_pkg::CP_W-1:0] CP_TAB     = 21'h09;
  localparam bit [srrc_pkg::CP_W-1:0] CP_LF      = 21'h0A;
  localparam bit [srrc_pkg::CP_W-1:0] CP_CR      = 21'h0D;
  localparam bit [srrc_pkg::CP_W-1:0] CP_SPACE   = 21'h20;
  localparam bit [srrc_pkg::CP_W-1:0] CP_LT      = 21'h3C;
  localparam bit [srrc_pkg::CP_W-1:0] CP_GT      = 21'h3E;
  localparam bit [srrc_pkg::CP_W-1:0] CP_N_UP    = 21'h4E;
  localparam bit [srrc_pkg::CP_W-1:0] CP_BSL     = 21'h5C;
  localparam bit [srrc_pkg::CP_W-1:0] CP_LOWER_A = 21'h61;
  localparam bit [srrc_pkg::CP_W-1:0] CP_N_LO    = 21'h6E;
  localparam bit [srrc_pkg::CP_W-1:0] CP_LBRACE  = 21'h7B;
  localparam bit [srrc_pkg::CP_W-1:0] CP_RBRACE  = 21'h7D;

  typedef struct {
    bit [srrc_pkg::CP_W-1:0]         cp;
    bit                              has_char;
    bit                              last;
    bit signed [srrc_pkg::DUR_W-1:0] dur;
  } text_item_t;

  typedef struct {
    bit [srrc_pkg::CP_W-1:0] cp;
    bit                      has_char;
  } glyph_t;

  typedef struct {
    bit [srrc_pkg::VIS_W-1:0]         vis;
    bit signed [srrc_pkg::RATE_W-1:0] rate;
    bit [srrc_pkg::STATUS_W-1:0]      status;
  } entry_rate_t;

  // Tracks the visible-character count of the running entry and holds the rates due
  class reading_rate_scoreboard;
    bit [srrc_pkg::CFG_W-1:0] min_dur;
    bit             in_angle;
    bit             in_curly;
    bit             held_bsl;
    bit             held_cr;
    bit             gap_pending;
    bit             any_visible;
    bit [srrc_pkg::VIS_W-1:0] shown;
    entry_rate_t    expected_rates[$];
    int unsigned    mismatches;
    int unsigned    compared;
    int unsigned    computed_n;
    int unsigned    not_pos_n;
    int unsigned    too_short_n;
    int unsigned    full_count_n;

    function new();
      min_dur = srrc_pkg::MIN_DUR_RESET;
      clear_entry();
    endfunction

    function void clear_entry();
      in_angle    = 1'b0;
      in_curly    = 1'b0;
      held_bsl    = 1'b0;
      held_cr     = 1'b0;
      gap_pending = 1'b0;
      any_visible = 1'b0;
      shown       = '0;
    endfunction

    function void count_one();
      if (shown != {srrc_pkg::VIS_W{1'b1}})
        shown++;
    endfunction

    // Collapse whitespace runs; a pending space only counts once text follows
    function void fold_space(bit [srrc_pkg::CP_W-1:0] c);
      if (c == CP_SPACE || (c >= CP_TAB && c <= CP_CR)) begin
        if (any_visible)
          gap_pending = 1'b1;
        return;
      end
      if (any_visible && gap_pending)
        count_one();
      count_one();
      any_visible = 1'b1;
      gap_pending = 1'b0;
    endfunction

    // Drop everything between angle or brace delimiters
    function void filter_tags(bit [srrc_pkg::CP_W-1:0] c);
      if (!in_angle && !in_curly) begin
        if (c == CP_LT)
          in_angle = 1'b1;
        else if (c == CP_LBRACE)
          in_curly = 1'b1;
        else
          fold_space(c == CP_LF ? CP_SPACE : c);
      end else if (in_angle && c == CP_GT) begin
        in_angle = 1'b0;
      end else if (in_curly && c == CP_RBRACE) begin
        in_curly = 1'b0;
      end
    endfunction

    // Turn CR LF, lone CR and backslash-N forms into newlines
    function void split_breaks(bit [srrc_pkg::CP_W-1:0] c);
      if (held_cr) begin
        held_cr = 1'b0;
        filter_tags(CP_LF);
        if (c == CP_LF)
          return;
      end
      if (held_bsl) begin
        held_bsl = 1'b0;
        if (c == CP_N_UP || c == CP_N_LO) begin
          filter_tags(CP_LF);
          return;
        end
        filter_tags(CP_BSL);
      end
      if (c == CP_CR) begin
        held_cr = 1'b1;
        return;
      end
      if (c == CP_BSL) begin
        held_bsl = 1'b1;
        return;
      end
      filter_tags(c);
    endfunction

    function void absorb_item(text_item_t it);
      longint      d;
      longint      q;
      entry_rate_t r;
      if (it.has_char)
        split_breaks(it.cp);
      if (!it.last)
        return;
      // Flush marks still held at the end of the entry
      if (held_cr) begin
        held_cr = 1'b0;
        filter_tags(CP_LF);
      end
      if (held_bsl) begin
        held_bsl = 1'b0;
        filter_tags(CP_BSL);
      end
      d = it.dur;
      r.vis = shown;
      if (shown == {srrc_pkg::VIS_W{1'b1}})
        full_count_n++;
      if (d <= 0) begin
        r.rate   = '0;
        r.status = srrc_pkg::ST_NOT_POSITIVE;
        not_pos_n++;
      end else if (d <= longint'(min_dur)) begin
        r.rate   = '1;
        r.status = srrc_pkg::ST_TOO_SHORT;
        too_short_n++;
      end else begin
        q = longint'(shown) * 1000 / d;
        if (q > RATE_MAX)
          q = RATE_MAX;
        r.rate   = q[srrc_pkg::RATE_W-1:0];
        r.status = srrc_pkg::ST_COMPUTED;
        computed_n++;
      end
      expected_rates.push_back(r);
      clear_entry();
    endfunction

    function void flag_error(string msg);
      if (mismatches < 10)
        $display("%s", msg);
      mismatches++;
    endfunction

    function void match_result(logic [srrc_pkg::VIS_W-1:0] vis,
                               logic signed [srrc_pkg::RATE_W-1:0] rate,
                               logic [srrc_pkg::STATUS_W-1:0] status);
      entry_rate_t e;
      compared++;
      if (expected_rates.size() == 0) begin
        flag_error($sformatf("unexpected result: visible %0d rate %0d status %0d",
                             vis, rate, status));
        return;
      end
      e = expected_rates.pop_front();
      if (vis !== e.vis || rate !== e.rate || status !== e.status)
        flag_error($sformatf({"mismatch on result %0d: visible exp %0d got %0d, ",
                              "rate exp %0d got %0d, status exp %0d got %0d"},
                             compared, e.vis, vis, e.rate, rate, e.status, status));
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  srrc_item_if   item_ch();
  srrc_result_if result_ch();
  srrc_cfg_if    cfg_ch();

  subtitle_reading_rate_counter dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  reading_rate_scoreboard sb = new();

  glyph_t      entry_text[$];
  int unsigned items_sent;
  int unsigned entries_sent;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  bit          hold_request;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: stop the run if no transfer happens on any channel for too long
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: check each transfer and stall at random, once for a long stretch
  initial begin : result_sink
    int unsigned run_left;
    int          r;
    bit          level;
    run_left = 0;
    level    = 1'b1;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        sb.match_result(result_ch.visible_chars, result_ch.chars_per_second,
                        result_ch.rate_status);
      if (run_left == 0) begin
        if (hold_request && !hold_done) begin
          level     = 1'b0;
          run_left  = HOLD_OFF;
          hold_done = 1'b1;
        end else begin
          r = $urandom_range(0, 9);
          if (r < 6) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 30);
          end else if (r < 9) begin
            level    = 1'b0;
            run_left = $urandom_range(1, 3);
          end else begin
            level    = 1'b0;
            run_left = $urandom_range(10, 40);
          end
        end
      end
      run_left--;
      result_ch.ready <= level;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(text_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.code_point <= it.cp;
    item_ch.char_valid <= it.has_char;
    item_ch.is_last    <= it.last;
    item_ch.span_ms    <= it.dur;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.absorb_item(it);
    if (it.has_char || it.last)
      items_sent++;
  endtask

  task automatic add_cp(input bit [srrc_pkg::CP_W-1:0] c);
    glyph_t g;
    g.cp       = c;
    g.has_char = 1'b1;
    entry_text.push_back(g);
  endtask

  task automatic add_blank();
    glyph_t g;
    g.cp       = srrc_pkg::CP_W'($urandom());
    g.has_char = 1'b0;
    entry_text.push_back(g);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_cp(s[i]);
  endtask

  // Send the collected text as one entry; an empty text becomes a lone empty last item
  task automatic emit_entry(input bit signed [srrc_pkg::DUR_W-1:0] dur);
    text_item_t it;
    if (entry_text.size() == 0)
      add_blank();
    foreach (entry_text[i]) begin
      it.cp       = entry_text[i].cp;
      it.has_char = entry_text[i].has_char;
      it.last     = (i == entry_text.size() - 1);
      if (it.last)
        it.dur = dur;
      else
        it.dur = srrc_pkg::DUR_W'($urandom());
      send_item(it);
    end
    entry_text.delete();
    entries_sent++;
  endtask

  function automatic bit signed [srrc_pkg::DUR_W-1:0] pick_duration();
    longint d;
    case ($urandom_range(0, 9))
      0: d = -longint'($urandom_range(1, 16777216));
      1: d = 0;
      2: d = sb.min_dur;
      3: d = longint'(sb.min_dur) + 1;
      4: d = $urandom_range(1, sb.min_dur);
      5: d = $urandom();
      default: begin
        d = $urandom_range(1, 20000);
        if ($urandom_range(0, 1))
          d += sb.min_dur;
      end
    endcase
    return d[srrc_pkg::DUR_W-1:0];
  endfunction

  function automatic bit [srrc_pkg::CP_W-1:0] any_letter();
    return srrc_pkg::CP_W'(CP_LOWER_A + $urandom_range(0, 25));
  endfunction

  // Mostly well-formed subtitle text with random content, some raw noise
  task automatic random_entry();
    int len;
    int r;
    int n;
    bit brace;
    glyph_t g;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        g.cp       = srrc_pkg::CP_W'($urandom());
        g.has_char = 1'($urandom_range(0, 1));
        entry_text.push_back(g);
      end
    end else begin
      len = $urandom_range(0, 24);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          add_cp(any_letter());
        end else if (r < 55) begin
          add_cp(CP_SPACE);
        end else if (r < 60) begin
          add_cp(srrc_pkg::CP_W'(CP_TAB + $urandom_range(0, 4)));
        end else if (r < 65) begin
          add_cp(CP_CR);
          if ($urandom_range(0, 1))
            add_cp(CP_LF);
        end else if (r < 70) begin
          add_cp(CP_BSL);
          case ($urandom_range(0, 2))
            0: add_cp(CP_N_UP);
            1: add_cp(CP_N_LO);
            default: add_cp(any_letter());
          endcase
        end else if (r < 84) begin
          brace = (r >= 77);
          add_cp(brace ? CP_LBRACE : CP_LT);
          n = $urandom_range(0, 3);
          repeat (n) add_cp($urandom_range(0, 3) == 0 ? CP_SPACE : any_letter());
          // leave the odd tag unclosed
          if ($urandom_range(0, 9) != 0)
            add_cp(brace ? CP_RBRACE : CP_GT);
        end else if (r < 88) begin
          add_cp($urandom_range(0, 1) ? CP_GT : CP_RBRACE);
        end else if (r < 92) begin
          add_cp(srrc_pkg::CP_W'($urandom_range(21'h80, 21'h1FFFFF)));
        end else if (r < 96) begin
          add_blank();
        end else begin
          add_cp(CP_LF);
        end
      end
    end
    emit_entry(pick_duration());
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target)
      random_entry();
  endtask

  // Drop valid, wait for every rate due, then let the divider settle
  task automatic drain_entries();
    item_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_min_duration(input bit [srrc_pkg::CFG_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.min_dur = v;
    cfg_writes++;
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.code_point  <= '0;
    item_ch.char_valid  <= 1'b0;
    item_ch.is_last     <= 1'b0;
    item_ch.span_ms     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    hold_request        = 1'b0;
    hold_done           = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed entries on the reset limit of 100 ms
    // empty text, duration just above the limit
    emit_entry(101);
    // leading space, CR LF, trailing CR; most negative duration
    add_cp(CP_SPACE);
    add_text("a");
    add_cp(CP_CR);
    add_cp(CP_LF);
    add_text("b");
    add_cp(CP_CR);
    emit_entry(-16777216);
    // angle and brace tags, backslash-n, trailing backslash; duration equal to the limit
    add_text("<i>c");
    add_cp(CP_BSL);
    add_text("nd{x}");
    add_cp(CP_BSL);
    emit_entry(100);
    // whitespace, code points beyond Unicode, backslash-N, empty item, unclosed brace
    add_cp(CP_TAB);
    add_cp(21'h1FFFFF);
    add_cp(21'h0B);
    add_cp(21'h110000);
    add_cp(CP_BSL);
    add_text("N");
    add_blank();
    add_text("{q");
    emit_entry(16777215);
    drain_entries();

    // No lower limit: a one-millisecond entry overflows the rate
    write_min_duration('0);
    repeat (70) add_cp(any_letter());
    emit_entry(1);
    hold_request = 1'b1;
    random_phase(PHASE_ITEMS);
    drain_entries();

    write_min_duration('1);
    random_phase(PHASE_ITEMS);
    drain_entries();

    write_min_duration(srrc_pkg::CFG_W'($urandom_range(1, 65534)));
    random_phase(PHASE_ITEMS);
    drain_entries();

    // Back to the usual limit
    write_min_duration(16'd100);
    random_phase(PHASE_ITEMS);
    drain_entries();

    $display("covered %0d text items over %0d entries, %0d results compared, %0d limit writes",
             items_sent, entries_sent, sb.compared, cfg_writes);
    $display("rates: %0d computed, %0d non-positive, %0d too short, %0d at full count",
             sb.computed_n, sb.not_pos_n, sb.too_short_n, sb.full_count_n);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
